FILE: rtl/core/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// Shared widths, codes, stage records and calendar tables for the date
// evaluator pipeline.
// ----------------------------------------------------------------------------
package cde_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int CENT_W   = 8;   // year / 100, up to 163
   localparam int REM_W    = 7;   // year % 100
   localparam int ZTERM_W  = 6;   // (13 * (m + 1)) / 5, up to 41
   localparam int SUM_W    = 11;  // Zeller sum, up to about 1080
   localparam int AFTER_W  = 9;   // days in later months, up to 366
   localparam int WDAY_W   = 3;
   localparam int MLEN_W   = 5;
   localparam int LEFT_M_W = 6;
   localparam int LEFT_Y_W = 10;

   // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
   localparam int             RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int             RECIP_SHIFT = 19;
   localparam int             PROD_W      = YEAR_W + RECIP_W;

   localparam logic [YEAR_W-1:0]  CENTURY   = 14'd100;
   localparam logic [REM_W-1:0]   REM_LAST  = 7'd99;
   localparam logic [CENT_W-1:0]  CYCLE_CENT = 8'd4;  // +400 years
   localparam logic [SUM_W-1:0]   WDAY_OFFSET = 11'd5; // Saturday=0 -> Monday=0

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

   localparam logic [WDAY_W-1:0]  WDAY_SAT = 3'd5;
   localparam logic [WDAY_W-1:0]  WDAY_SUN = 3'd6;
   localparam logic [WDAY_W:0]    MOD7     = 4'd7;

   typedef struct packed {
      logic               valid;
      logic [CENT_W-1:0]  cent;
      logic [REM_W-1:0]   rem;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } stage_b_type;

   typedef struct packed {
      logic               valid;
      logic [SUM_W-1:0]   sum;
      logic               leap;
      logic [MLEN_W-1:0]  mlen;
      logic [AFTER_W-1:0] after;
      logic [DAY_W-1:0]   day;
   } stage_c_type;

   // (13 * (mm + 1)) / 5 with January and February as months 13 and 14
   function automatic logic [ZTERM_W-1:0] zeller_month_term(input logic [MONTH_W-1:0] m);
      logic [ZTERM_W-1:0] t;
      case (m)
         4'd0:    t = 6'd2;
         4'd1:    t = 6'd36;
         4'd2:    t = 6'd39;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         4'd13:   t = 6'd36;
         4'd14:   t = 6'd39;
         default: t = 6'd41;
      endcase
      return t;
   endfunction

   function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      logic [MLEN_W-1:0] n;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
         MONTH_FEB:                                  n = 5'd28 + MLEN_W'(leap);
         default:                                    n = 5'd0;
      endcase
      return n;
   endfunction

   // days in the months after m through December
   function automatic logic [AFTER_W-1:0] days_after(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [AFTER_W-1:0] n;
      case (m)
         4'd0:    n = 9'd365 + AFTER_W'(leap);
         4'd1:    n = 9'd334 + AFTER_W'(leap);
         4'd2:    n = 9'd306;
         4'd3:    n = 9'd275;
         4'd4:    n = 9'd245;
         4'd5:    n = 9'd214;
         4'd6:    n = 9'd184;
         4'd7:    n = 9'd153;
         4'd8:    n = 9'd122;
         4'd9:    n = 9'd92;
         4'd10:   n = 9'd61;
         4'd11:   n = 9'd31;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // x % 7 by folding octal digits (8 == 1 mod 7)
   function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] x);
      logic [4:0] f1;
      logic [3:0] f2;
      logic [3:0] f3;
      f1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
      f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
      f3 = 4'(f2[2:0]) + 4'(f2[3]);
      if (f3 >= MOD7) begin
         f3 = f3 - MOD7;
      end
      return f3[WDAY_W-1:0];
   endfunction

endpackage

FILE: rtl/core/cde_div100.sv
// ----------------------------------------------------------------------------
// cde_div100
// Two stages: reciprocal multiply for year / 100, then the remainder.
// ----------------------------------------------------------------------------
module cde_div100 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [cde_pkg::YEAR_W-1:0]    in_year,
   input  logic [cde_pkg::MONTH_W-1:0]   in_month,
   input  logic [cde_pkg::DAY_W-1:0]     in_day,
   output cde_pkg::stage_b_type          stage_b
);
   import cde_pkg::*;

   logic               a_valid_ff;
   logic [PROD_W-1:0]  a_prod_ff, a_prod_in;
   logic [YEAR_W-1:0]  a_year_ff;
   logic [MONTH_W-1:0] a_month_ff;
   logic [DAY_W-1:0]   a_day_ff;

   logic [CENT_W-1:0]  cent;
   logic [YEAR_W-1:0]  diff;
   stage_b_type        b_ff, b_in;

   assign a_prod_in = PROD_W'(in_year) * PROD_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_prod_ff  <= a_prod_in;
      a_year_ff  <= in_year;
      a_month_ff <= in_month;
      a_day_ff   <= in_day;
   end

   assign cent = a_prod_ff[RECIP_SHIFT +: CENT_W];
   assign diff = a_year_ff - (YEAR_W'(cent) * CENTURY);

   always_comb begin
      b_in.valid = a_valid_ff;
      b_in.cent  = cent;
      b_in.rem   = diff[REM_W-1:0];
      b_in.month = a_month_ff;
      b_in.day   = a_day_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else begin
         b_ff.valid <= b_in.valid;
      end
      b_ff.cent  <= b_in.cent;
      b_ff.rem   <= b_in.rem;
      b_ff.month <= b_in.month;
      b_ff.day   <= b_in.day;
   end

   assign stage_b = b_ff;

endmodule

FILE: rtl/core/cde_calc.sv
// ----------------------------------------------------------------------------
// cde_calc
// Leap year, month tables and the Zeller sum (offset folded in).
// ----------------------------------------------------------------------------
module cde_calc (
   input  logic                 clock,
   input  logic                 reset,
   input  cde_pkg::stage_b_type stage_b,
   output cde_pkg::stage_c_type stage_c
);
   import cde_pkg::*;

   logic               early;
   logic               leap;
   logic [REM_W-1:0]   k;
   logic [CENT_W-1:0]  j;
   stage_c_type        c_ff, c_in;

   // Jan/Feb belong to the previous year; year + 400 keeps it non-negative
   assign early = (stage_b.month == MONTH_JAN) || (stage_b.month == MONTH_FEB);

   always_comb begin
      if (early && stage_b.rem == '0) begin
         k = REM_LAST;
         j = stage_b.cent + CYCLE_CENT - CENT_W'(1);
      end else if (early) begin
         k = stage_b.rem - REM_W'(1);
         j = stage_b.cent + CYCLE_CENT;
      end else begin
         k = stage_b.rem;
         j = stage_b.cent + CYCLE_CENT;
      end
   end

   assign leap = (stage_b.rem != '0) ? (stage_b.rem[1:0] == 2'b00)
                                     : (stage_b.cent[1:0] == 2'b00);

   always_comb begin
      c_in.valid = stage_b.valid;
      c_in.sum   = SUM_W'(stage_b.day) + SUM_W'(zeller_month_term(stage_b.month))
                 + SUM_W'(k) + SUM_W'(k >> 2) + SUM_W'(j >> 2)
                 + (SUM_W'(j) << 2) + SUM_W'(j) + WDAY_OFFSET;
      c_in.leap  = leap;
      c_in.mlen  = month_days(stage_b.month, leap);
      c_in.after = days_after(stage_b.month, leap);
      c_in.day   = stage_b.day;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else begin
         c_ff.valid <= c_in.valid;
      end
      c_ff.sum   <= c_in.sum;
      c_ff.leap  <= c_in.leap;
      c_ff.mlen  <= c_in.mlen;
      c_ff.after <= c_in.after;
      c_ff.day   <= c_in.day;
   end

   assign stage_c = c_ff;

endmodule

FILE: rtl/core/cde_finish.sv
// ----------------------------------------------------------------------------
// cde_finish
// Weekday reduction, remaining-day counts and the result register.
// ----------------------------------------------------------------------------
module cde_finish (
   input  logic                                clock,
   input  logic                                reset,
   input  cde_pkg::stage_c_type                stage_c,
   output logic                                out_valid,
   output logic [cde_pkg::WDAY_W-1:0]          out_weekday,
   output logic                                out_weekend,
   output logic                                out_sunday,
   output logic [cde_pkg::WDAY_W-1:0]          out_left_week,
   output logic                                out_leap,
   output logic [cde_pkg::MLEN_W-1:0]          out_mlen,
   output logic signed [cde_pkg::LEFT_M_W-1:0] out_left_month,
   output logic signed [cde_pkg::LEFT_Y_W-1:0] out_left_year
);
   import cde_pkg::*;

   logic                       valid_ff;
   logic [WDAY_W-1:0]          wday_ff, wday_in;
   logic                       weekend_ff, sunday_ff, leap_ff;
   logic [WDAY_W-1:0]          left_week_ff;
   logic [MLEN_W-1:0]          mlen_ff;
   logic signed [LEFT_M_W-1:0] left_month_ff, left_month_in;
   logic signed [LEFT_Y_W-1:0] left_year_ff, left_year_in;

   assign wday_in       = mod7(stage_c.sum);
   assign left_month_in = LEFT_M_W'(stage_c.mlen) - LEFT_M_W'(stage_c.day);
   assign left_year_in  = LEFT_Y_W'(stage_c.after)
                        + {{(LEFT_Y_W-LEFT_M_W){left_month_in[LEFT_M_W-1]}}, left_month_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_c.valid;
      end
      wday_ff       <= wday_in;
      weekend_ff    <= (wday_in >= WDAY_SAT);
      sunday_ff     <= (wday_in == WDAY_SUN);
      left_week_ff  <= WDAY_SUN - wday_in;
      leap_ff       <= stage_c.leap;
      mlen_ff       <= stage_c.mlen;
      left_month_ff <= left_month_in;
      left_year_ff  <= left_year_in;
   end

   assign out_valid      = valid_ff;
   assign out_weekday    = wday_ff;
   assign out_weekend    = weekend_ff;
   assign out_sunday     = sunday_ff;
   assign out_left_week  = left_week_ff;
   assign out_leap       = leap_ff;
   assign out_mlen       = mlen_ff;
   assign out_left_month = left_month_ff;
   assign out_left_year  = left_year_ff;

endmodule

FILE: rtl/core/calendar_date_evaluator.sv
// ----------------------------------------------------------------------------
// calendar_date_evaluator
// Gregorian date to weekday (Zeller, Monday = 0), leap flag, month length
// and days remaining in the week, month and year.
//
//   channel   ports                 handshake
//   -------   -------------------   ------------------------------------
//   request   req_year/month/day    start high and busy low at the edge
//   result    rsp_*                 rsp_valid for one cycle, no backpressure
//
// One item per cycle while busy is low; four register stages lie between
// the edge that takes an item and its result on the ports.
// The stages are: reciprocal multiply for year / 100, remainder, Zeller sum
// and month tables, then mod-7 fold and the result register.
// Synchronous reset empties the pipeline; busy is high only during reset.
// The pipeline never stalls, since the receiver takes every result.
// ----------------------------------------------------------------------------
module calendar_date_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cde_pkg::YEAR_W-1:0]          req_year_num,
   input  logic [cde_pkg::MONTH_W-1:0]         req_month_num,
   input  logic [cde_pkg::DAY_W-1:0]           req_day_num,
   output logic                                rsp_valid,
   output logic [cde_pkg::WDAY_W-1:0]          rsp_weekday,
   output logic                                rsp_weekend_flag,
   output logic                                rsp_sunday_flag,
   output logic [cde_pkg::WDAY_W-1:0]          rsp_days_left_in_week,
   output logic                                rsp_leap_flag,
   output logic [cde_pkg::MLEN_W-1:0]          rsp_month_length,
   output logic signed [cde_pkg::LEFT_M_W-1:0] rsp_days_left_in_month,
   output logic signed [cde_pkg::LEFT_Y_W-1:0] rsp_days_left_in_year
);
   import cde_pkg::*;

   logic        accept;
   stage_b_type stage_b;
   stage_c_type stage_c;

   assign busy   = reset;
   assign accept = start && !busy;

   cde_div100 u_div100 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_year  (req_year_num),
      .in_month (req_month_num),
      .in_day   (req_day_num),
      .stage_b  (stage_b)
   );

   cde_calc u_calc (
      .clock   (clock),
      .reset   (reset),
      .stage_b (stage_b),
      .stage_c (stage_c)
   );

   cde_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .stage_c        (stage_c),
      .out_valid      (rsp_valid),
      .out_weekday    (rsp_weekday),
      .out_weekend    (rsp_weekend_flag),
      .out_sunday     (rsp_sunday_flag),
      .out_left_week  (rsp_days_left_in_week),
      .out_leap       (rsp_leap_flag),
      .out_mlen       (rsp_month_length),
      .out_left_month (rsp_days_left_in_month),
      .out_left_year  (rsp_days_left_in_year)
   );

   // every item taken comes out at the result port
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("item did not reach the result port after four cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("result strobe without a matching item");

   a_feb_leap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_month_length == 5'd29) |-> rsp_leap_flag)
      else $error("29-day month reported in a common year");

   a_weekend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday <= WDAY_SUN)
                 && (rsp_weekend_flag == (rsp_weekday >= WDAY_SAT)))
      else $error("weekday out of range or weekend flag inconsistent");

endmodule

FILE: tb/calendar_date_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_evaluator_tb
// Drives dates through the evaluator and checks every result against a
// behavioral calendar computed in the bench. A short directed sweep of edge
// dates is followed by random dates, under several sender idling mixes.
// ----------------------------------------------------------------------------
module calendar_date_evaluator_tb;

   import cde_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int ITEMS_PER_MIX  = 425;

   typedef struct {
      logic [WDAY_W-1:0]          weekday;
      logic                       weekend_flag;
      logic                       sunday_flag;
      logic [WDAY_W-1:0]          days_left_in_week;
      logic                       leap_flag;
      logic [MLEN_W-1:0]          month_length;
      logic signed [LEFT_M_W-1:0] days_left_in_month;
      logic signed [LEFT_Y_W-1:0] days_left_in_year;
   } date_facts_type;

   class date_scoreboard;
      date_facts_type pending_facts[$];
      int             errors       = 0;
      int             dates_taken  = 0;
      int             dates_graded = 0;
      int             leap_dates   = 0;
      int             odd_dates    = 0;

      static function bit is_leap(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      static function int unsigned month_span(int unsigned m, int unsigned y);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            MONTH_FEB:             return is_leap(y) ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      function date_facts_type evaluate_date(int unsigned y, int unsigned m, int unsigned d);
         date_facts_type f;
         int unsigned    yy;
         int unsigned    mm;
         int unsigned    k;
         int unsigned    j;
         int unsigned    wd;
         int             left_month;
         int             left_year;
         // shift by a full 400-year cycle so January of year 0 stays positive
         yy = y + 400;
         mm = m;
         if (m == MONTH_JAN) begin
            mm = 13;
            yy = yy - 1;
         end else if (m == MONTH_FEB) begin
            mm = 14;
            yy = yy - 1;
         end
         k  = yy % 100;
         j  = yy / 100;
         wd = ((d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7 + 5) % 7;
         left_month = int'(month_span(m, y)) - int'(d);
         left_year  = left_month;
         for (int unsigned i = m + 1; i <= 12; i++) begin
            left_year += int'(month_span(i, y));
         end
         f.weekday            = wd[WDAY_W-1:0];
         f.weekend_flag       = (wd >= WDAY_SAT);
         f.sunday_flag        = (wd == WDAY_SUN);
         f.days_left_in_week  = WDAY_W'(6 - wd);
         f.leap_flag          = is_leap(y);
         f.month_length       = MLEN_W'(month_span(m, y));
         f.days_left_in_month = LEFT_M_W'(left_month);
         f.days_left_in_year  = LEFT_Y_W'(left_year);
         return f;
      endfunction

      function void note_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                              logic [DAY_W-1:0] d);
         pending_facts.push_back(evaluate_date(y, m, d));
         dates_taken++;
         if (is_leap(y)) leap_dates++;
         if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > month_span(m, y))
            odd_dates++;
      endfunction

      function void check_result(date_facts_type act);
         date_facts_type exp;
         if (pending_facts.size() == 0) begin
            $error("result with no date outstanding");
            errors++;
            return;
         end
         exp = pending_facts.pop_front();
         dates_graded++;
         if (act.weekday !== exp.weekday) begin
            $error("weekday: expected %0d, actual %0d", exp.weekday, act.weekday);
            errors++;
         end
         if (act.weekend_flag !== exp.weekend_flag) begin
            $error("weekend_flag: expected %0d, actual %0d",
                   exp.weekend_flag, act.weekend_flag);
            errors++;
         end
         if (act.sunday_flag !== exp.sunday_flag) begin
            $error("sunday_flag: expected %0d, actual %0d",
                   exp.sunday_flag, act.sunday_flag);
            errors++;
         end
         if (act.days_left_in_week !== exp.days_left_in_week) begin
            $error("days_left_in_week: expected %0d, actual %0d",
                   exp.days_left_in_week, act.days_left_in_week);
            errors++;
         end
         if (act.leap_flag !== exp.leap_flag) begin
            $error("leap_flag: expected %0d, actual %0d", exp.leap_flag, act.leap_flag);
            errors++;
         end
         if (act.month_length !== exp.month_length) begin
            $error("month_length: expected %0d, actual %0d",
                   exp.month_length, act.month_length);
            errors++;
         end
         if (act.days_left_in_month !== exp.days_left_in_month) begin
            $error("days_left_in_month: expected %0d, actual %0d",
                   exp.days_left_in_month, act.days_left_in_month);
            errors++;
         end
         if (act.days_left_in_year !== exp.days_left_in_year) begin
            $error("days_left_in_year: expected %0d, actual %0d",
                   exp.days_left_in_year, act.days_left_in_year);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_facts.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       start         = 1'b0;
   logic                       busy;
   logic [YEAR_W-1:0]          req_year_num  = '0;
   logic [MONTH_W-1:0]         req_month_num = '0;
   logic [DAY_W-1:0]           req_day_num   = '0;
   logic                       rsp_valid;
   logic [WDAY_W-1:0]          rsp_weekday;
   logic                       rsp_weekend_flag;
   logic                       rsp_sunday_flag;
   logic [WDAY_W-1:0]          rsp_days_left_in_week;
   logic                       rsp_leap_flag;
   logic [MLEN_W-1:0]          rsp_month_length;
   logic signed [LEFT_M_W-1:0] rsp_days_left_in_month;
   logic signed [LEFT_Y_W-1:0] rsp_days_left_in_year;

   date_scoreboard sb;
   int             idle_pct = 0;

   calendar_date_evaluator dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_year_num           (req_year_num),
      .req_month_num          (req_month_num),
      .req_day_num            (req_day_num),
      .rsp_valid              (rsp_valid),
      .rsp_weekday            (rsp_weekday),
      .rsp_weekend_flag       (rsp_weekend_flag),
      .rsp_sunday_flag        (rsp_sunday_flag),
      .rsp_days_left_in_week  (rsp_days_left_in_week),
      .rsp_leap_flag          (rsp_leap_flag),
      .rsp_month_length       (rsp_month_length),
      .rsp_days_left_in_month (rsp_days_left_in_month),
      .rsp_days_left_in_year  (rsp_days_left_in_year)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // values read right after the edge are the ones the block saw at it
   always @(posedge clock) begin : observe
      date_facts_type act;
      if (!reset && start && !busy) begin
         sb.note_date(req_year_num, req_month_num, req_day_num);
      end
      if (!reset && rsp_valid) begin
         act.weekday            = rsp_weekday;
         act.weekend_flag       = rsp_weekend_flag;
         act.sunday_flag        = rsp_sunday_flag;
         act.days_left_in_week  = rsp_days_left_in_week;
         act.leap_flag          = rsp_leap_flag;
         act.month_length       = rsp_month_length;
         act.days_left_in_month = rsp_days_left_in_month;
         act.days_left_in_year  = rsp_days_left_in_year;
         sb.check_result(act);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("[calendar_date_evaluator] ERROR");
      $finish;
   end

   task automatic send_date(input int unsigned y, input int unsigned m,
                            input int unsigned d);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_year_num  <= YEAR_W'(y);
      req_month_num <= MONTH_W'(m);
      req_day_num   <= DAY_W'(d);
      do @(posedge clock); while (busy);
   endtask

   task automatic send_random_date();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned pick;
      pick = $urandom_range(99);
      m    = $urandom_range(12, 1);
      y    = $urandom_range(9999, 1);
      if (pick < 70) begin
         d = $urandom_range(date_scoreboard::month_span(m, y), 1);
      end else if (pick < 80) begin
         // century years exercise the 100 and 400 leap rules
         y = 100 * $urandom_range(99, 1);
         d = $urandom_range(date_scoreboard::month_span(m, y), 1);
      end else if (pick < 90) begin
         d = $urandom_range(31, date_scoreboard::month_span(m, y) + 1);
      end else begin
         y = $urandom_range((1 << YEAR_W) - 1);
         m = $urandom_range((1 << MONTH_W) - 1);
         d = $urandom_range((1 << DAY_W) - 1);
      end
      send_date(y, m, d);
   endtask

   initial begin : main
      int idle_mix[4];
      sb = new();
      // result side cannot stall, so its stall mixes reduce to sender idling only
      idle_mix = '{0, 54, 0, 28};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_date(1, 1, 1);
      send_date(9999, 12, 31);
      send_date(0, 1, 1);
      send_date(0, 2, 29);
      send_date(16383, 15, 31);
      send_date(2000, 2, 29);
      send_date(1900, 2, 31);
      send_date(2023, 12, 0);
      send_date(8191, 0, 0);
      for (int unsigned m = 0; m < 16; m++) begin
         send_date(1996 + m, m, (2 * m + 1) % 32);
      end

      foreach (idle_mix[p]) begin
         idle_pct = idle_mix[p];
         repeat (ITEMS_PER_MIX) send_random_date();
      end
      start <= 1'b0;

      while (sb.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d dates (%0d leap-year, %0d off-calendar), %0d results checked",
               sb.dates_taken, sb.leap_dates, sb.odd_dates, sb.dates_graded);
      if (sb.errors == 0) begin
         $display("[calendar_date_evaluator] OK");
      end else begin
         $display("[calendar_date_evaluator] ERROR");
      end
      $finish;
   end

endmodule

FILE: calendar_date_evaluator.f
rtl/core/cde_pkg.sv
rtl/core/cde_div100.sv
rtl/core/cde_calc.sv
rtl/core/cde_finish.sv
rtl/core/calendar_date_evaluator.sv
tb/calendar_date_evaluator_tb.sv
